>>> rtl/orqa_pkg.sv
// ----------------------------------------------------------------------------
// orqa_pkg: shared types and constants for the overwrite ring queue
// Field widths, stream word widths, operation codes and controller states.
// ----------------------------------------------------------------------------
package orqa_pkg;

	localparam int TAG_W     = 16;
	localparam int YEAR_W    = 14;
	localparam int COUNT_O_W = 4;

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 48;
	localparam int M_TUSER_W = 2;

	localparam int ENTRY_W   = TAG_W + YEAR_W;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_OUT
	} orqa_state_t;

endpackage

>>> rtl/orqa_ram.sv
// ----------------------------------------------------------------------------
// orqa_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module orqa_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/overwrite_ring_queue_with_average.sv
// ----------------------------------------------------------------------------
// overwrite_ring_queue_with_average: ring queue that overwrites its oldest word
//
// Input stream: s_axis_tuser selects the operation (0 insert, 1 remove
// oldest); s_axis_tdata carries the tag and year of an inserted entry.
// Output stream: one word per input word with the removed entry, the drop
// flag, the entry count after the operation and the truncated mean year.
// Entries live in one RAM with registered read. The head entry is read
// in the cycle after acceptance, the queue is updated in that cycle, then
// a restoring divider produces the mean one quotient bit per cycle.
// The mean divides the running sum, SUM_W = 14 + clog2(DEPTH) bits wide
// (17 at DEPTH = 8); when the queue ends up empty the divider is skipped.
// One word at a time: a new word is taken only once the last result has
// moved to the output register; s_axis_tready rises when idle, even while
// a finished result still waits in the output register.
// A stalled receiver holds the output register and the next result waits
// in the controller until the register frees up.
// Reset empties the queue (pointers, count and sum cleared); RAM contents
// are not cleared and are never used before being written.
// ----------------------------------------------------------------------------
module overwrite_ring_queue_with_average #(
	parameter int DEPTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [15:0] new_tag, [29:16] new_year, [31:30] zero
	input  logic [orqa_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// [0] action
	input  logic [orqa_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [15:0] removed_tag, [29:16] removed_year, [33:30] entry_count,
	// [47:34] mean_year
	output logic [orqa_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// [0] removed_valid, [1] dropped_oldest
	output logic [orqa_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

	import orqa_pkg::*;

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = YEAR_W + $clog2(DEPTH);
	localparam int STEP_W = $clog2(SUM_W);

	orqa_state_t state_q, state_d;

	logic [PTR_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;

	logic              act_q;
	logic [TAG_W-1:0]  in_tag_q;
	logic [YEAR_W-1:0] in_year_q;

	logic              res_valid_q, res_drop_q;
	logic [TAG_W-1:0]  res_tag_q;
	logic [YEAR_W-1:0] res_year_q;

	logic [SUM_W-1:0]  quot_q;
	logic [CNT_W-1:0]  rem_q, div_q;
	logic [STEP_W-1:0] step_q;

	logic              out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic [M_TUSER_W-1:0] out_user_q;

	logic              accept, load_out, ram_we;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [TAG_W-1:0]  old_tag;
	logic [YEAR_W-1:0] old_year;

	// queue update, valid in ST_EXEC
	logic              full;
	logic [PTR_W-1:0]  head_nxt, tail_nxt;
	logic [PTR_W-1:0]  head_n, tail_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [SUM_W-1:0]  sum_n;
	logic              take;

	// divider step
	logic [CNT_W:0]    trial, diff;
	logic              ge;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign old_tag  = ram_rdata[TAG_W-1:0];
	assign old_year = ram_rdata[ENTRY_W-1:TAG_W];

	orqa_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata ({in_year_q, in_tag_q}),
		.re    (accept),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		full     = (cnt_q == CNT_W'(DEPTH));
		head_nxt = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
		tail_nxt = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
		head_n   = head_q;
		tail_n   = tail_q;
		cnt_n    = cnt_q;
		sum_n    = sum_q;
		take     = 1'b0;
		if (act_q == ACT_INSERT) begin
			tail_n = tail_nxt;
			if (full) begin
				// drop oldest, count stays at DEPTH
				head_n = head_nxt;
				sum_n  = sum_q - SUM_W'(old_year) + SUM_W'(in_year_q);
			end else begin
				cnt_n = cnt_q + 1'b1;
				sum_n = sum_q + SUM_W'(in_year_q);
			end
		end else if (cnt_q != '0) begin
			take   = 1'b1;
			head_n = head_nxt;
			cnt_n  = cnt_q - 1'b1;
			sum_n  = sum_q - SUM_W'(old_year);
		end
	end

	always_comb begin
		trial = {rem_q, quot_q[SUM_W-1]};
		ge    = (trial >= {1'b0, div_q});
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ram_we  = (act_q == ACT_INSERT);
				state_d = (cnt_n == '0) ? ST_OUT : ST_DIV;
			end
			ST_DIV: begin
				if (step_q == '0) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			sum_q  <= '0;
			step_q <= '0;
		end else if (state_q == ST_EXEC) begin
			head_q <= head_n;
			tail_q <= tail_n;
			cnt_q  <= cnt_n;
			sum_q  <= sum_n;
			step_q <= STEP_W'(SUM_W - 1);
		end else if (state_q == ST_DIV) begin
			step_q <= step_q - 1'b1;
		end
	end

	// item, result and divider payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= s_axis_tuser[0];
			in_tag_q  <= s_axis_tdata[TAG_W-1:0];
			in_year_q <= s_axis_tdata[TAG_W+YEAR_W-1:TAG_W];
		end
		if (state_q == ST_EXEC) begin
			res_valid_q <= take;
			res_drop_q  <= (act_q == ACT_INSERT) && full;
			res_tag_q   <= take ? old_tag : '0;
			res_year_q  <= take ? old_year : '0;
			quot_q      <= (cnt_n == '0) ? '0 : sum_n;
			rem_q       <= '0;
			div_q       <= cnt_n;
		end else if (state_q == ST_DIV) begin
			quot_q <= {quot_q[SUM_W-2:0], ge};
			rem_q  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {quot_q[YEAR_W-1:0], COUNT_O_W'(cnt_q), res_year_q, res_tag_q};
			out_user_q <= {res_drop_q, res_valid_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for overwrite_ring_queue_with_average
// Drives insert and remove words into the ring queue, keeps a shadow copy of
// the queue to predict every output word, and compares each output word
// field by field. Covers an empty queue, extreme tags and years, overflow
// with dropping of the oldest entry, pointer wrap, and long random traffic
// with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import orqa_pkg::*;

	localparam int DEPTH        = 8;
	localparam int RANDOM_WORDS = 1150;
	localparam int CALM_WORDS   = 150;
	localparam int HOLD_OFF     = 40;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic                 removed_valid;
		logic [TAG_W-1:0]     removed_tag;
		logic [YEAR_W-1:0]    removed_year;
		logic                 dropped_oldest;
		logic [COUNT_O_W-1:0] entry_count;
		logic [YEAR_W-1:0]    mean_year;
	} queue_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [S_TUSER_W-1:0] s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b1;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [M_TUSER_W-1:0] m_axis_tuser;

	// shadow copy of the queue
	logic [TAG_W-1:0]  shadow_tag [DEPTH];
	logic [YEAR_W-1:0] shadow_year [DEPTH];
	int unsigned       shadow_head = 0;
	int unsigned       shadow_tail = 0;
	int unsigned       shadow_fill = 0;
	int unsigned       shadow_sum  = 0;

	queue_result_t pending_results[$];
	queue_result_t seen_result;
	queue_result_t due_result;
	int            mismatches = 0;
	int            stall_left = 0;
	int            cycle_count = 0;
	logic          quiet_tail = 1'b0;

	overwrite_ring_queue_with_average #(
		.DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Update the shadow queue with one word and return the word it should produce.
	function automatic queue_result_t apply_to_shadow_queue(input logic act,
			input logic [TAG_W-1:0] tag, input logic [YEAR_W-1:0] yr);
		queue_result_t r;
		r = '0;
		if (act == ACT_INSERT) begin
			if (shadow_fill == DEPTH) begin
				shadow_sum -= shadow_year[shadow_head];
				shadow_head = (shadow_head + 1) % DEPTH;
				shadow_fill--;
				r.dropped_oldest = 1'b1;
			end
			shadow_tag[shadow_tail] = tag;
			shadow_year[shadow_tail] = yr;
			shadow_sum += yr;
			shadow_tail = (shadow_tail + 1) % DEPTH;
			shadow_fill++;
		end else if (shadow_fill != 0) begin
			r.removed_valid = 1'b1;
			r.removed_tag = shadow_tag[shadow_head];
			r.removed_year = shadow_year[shadow_head];
			shadow_sum -= shadow_year[shadow_head];
			shadow_head = (shadow_head + 1) % DEPTH;
			shadow_fill--;
		end
		r.entry_count = COUNT_O_W'(shadow_fill);
		if (shadow_fill != 0)
			r.mean_year = YEAR_W'(shadow_sum / shadow_fill);
		return r;
	endfunction

	function automatic logic [YEAR_W-1:0] pick_year();
		// mostly calendar years, now and then the full 14-bit range
		if ($urandom_range(0, 7) == 0)
			return YEAR_W'($urandom_range(0, 16383));
		return YEAR_W'($urandom_range(0, 9999));
	endfunction

	task automatic send_word(input logic act, input logic [TAG_W-1:0] tag,
			input logic [YEAR_W-1:0] yr);
		int gap;
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 17);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, yr, tag};
		s_axis_tuser <= act;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(apply_to_shadow_queue(act, tag, yr));
	endtask

	// Hold the sender until every outstanding word has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_result.removed_valid = m_axis_tuser[0];
			seen_result.dropped_oldest = m_axis_tuser[1];
			seen_result.removed_tag = m_axis_tdata[15:0];
			seen_result.removed_year = m_axis_tdata[29:16];
			seen_result.entry_count = m_axis_tdata[33:30];
			seen_result.mean_year = m_axis_tdata[47:34];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected output word, expected none, got %0h",
					$time, seen_result);
				mismatches++;
			end else begin
				due_result = pending_results.pop_front();
				check_field("removed_valid", due_result.removed_valid,
					seen_result.removed_valid);
				check_field("removed_tag", due_result.removed_tag, seen_result.removed_tag);
				check_field("removed_year", due_result.removed_year, seen_result.removed_year);
				check_field("dropped_oldest", due_result.dropped_oldest,
					seen_result.dropped_oldest);
				check_field("entry_count", due_result.entry_count, seen_result.entry_count);
				check_field("mean_year", due_result.mean_year, seen_result.mean_year);
			end
		end
		// stall the output side in bursts
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 16);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic test_extremes();
		send_word(ACT_REMOVE, 16'hFFFF, 14'h3FFF);
		send_word(ACT_INSERT, 16'h0000, 14'h0000);
		send_word(ACT_INSERT, 16'hFFFF, 14'h3FFF);
		send_word(ACT_INSERT, 16'h5A5A, 14'd9999);
		send_word(ACT_REMOVE, 16'h0000, 14'h0000);
		send_word(ACT_REMOVE, 16'h1234, 14'h2AAA);
		send_word(ACT_REMOVE, 16'h4321, 14'h1555);
		send_word(ACT_REMOVE, 16'hFFFF, 14'h3FFF);
	endtask

	task automatic test_overflow_and_wrap();
		for (int i = 0; i < DEPTH + 2; i++)
			send_word(ACT_INSERT, TAG_W'(16'hA000 + i), YEAR_W'(1900 + 37 * i));
		for (int i = 0; i < DEPTH + 1; i++)
			send_word(ACT_REMOVE, TAG_W'($urandom), pick_year());
	endtask

	task automatic test_random_traffic();
		int sent;
		int seg_len;
		int insert_pct;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 3))
				0: insert_pct = 20;
				1: insert_pct = 50;
				2: insert_pct = 75;
				default: insert_pct = 95;
			endcase
			seg_len = $urandom_range(10, 60);
			for (int k = 0; k < seg_len && sent < RANDOM_WORDS; k++) begin
				if (sent == RANDOM_WORDS - CALM_WORDS)
					quiet_tail = 1'b1;
				send_word(($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE,
					TAG_W'($urandom), pick_year());
				sent++;
			end
			if (!quiet_tail && $urandom_range(0, 7) == 0)
				drain_results();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_overflow_and_wrap();
		drain_results();
		test_random_traffic();
		drain_results();
		repeat (HOLD_OFF) @(posedge clk);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> sim.f
rtl/orqa_pkg.sv
rtl/orqa_ram.sv
rtl/overwrite_ring_queue_with_average.sv
bench/testbench.sv
